// ===== sv/att_pkg.sv =====
`timescale 1ns / 1ps
// att_pkg: shared types and constants for the appliance tick timer set
// used by every module of the block; depends on nothing

package att_pkg;

   localparam int PWM_TOP_DEF = 100;

   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_MASS_TIMEOUT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEAT_TIMEOUT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_PHASE_LIMIT = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOCK_HOLD_LIMIT = 8'd3;

   localparam logic [15:0] MASS_TIMEOUT_RST = 16'd1800;
   localparam logic [15:0] HEAT_TIMEOUT_RST = 16'd3600;
   localparam logic [15:0] MOTOR_PHASE_LIMIT_RST = 16'd1500;
   localparam logic [15:0] LOCK_HOLD_LIMIT_RST = 16'd1000;

   localparam logic [7:0] CODE_MASS_OFF = 8'h21;
   localparam logic [7:0] CODE_HEAT_OFF = 8'h20;
   localparam logic [7:0] CODE_NONE = 8'h00;

   typedef struct packed {
      logic [15:0] mass_timeout;
      logic [15:0] heat_timeout;
      logic [15:0] motor_phase_limit;
      logic [15:0] lock_hold_limit;
   } att_cfg_type;

   typedef struct packed {
      logic [7:0] light_level;
      logic       lock_key_seen;
      logic       set_up;
      logic       set_down;
      logic       arm_mass;
      logic       arm_heat;
   } att_req_type;

   typedef struct packed {
      logic       foot_light_on;
      logic       red_light_on;
      logic       locked;
      logic       up_active;
      logic       down_active;
      logic       motor_off_pulse;
      logic       tx_valid;
      logic [7:0] tx_code;
   } att_rsp_type;

endpackage

// ===== sv/att_req_if.sv =====
`timescale 1ns / 1ps
// att_req_if: tick item channel, valid/ready handshake with payload
// no dependencies

interface att_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] light_level;
   logic       lock_key_seen;
   logic       set_up;
   logic       set_down;
   logic       arm_mass;
   logic       arm_heat;

   modport source (output valid, light_level, lock_key_seen, set_up, set_down,
                   arm_mass, arm_heat, input ready);
   modport sink (input valid, light_level, lock_key_seen, set_up, set_down,
                 arm_mass, arm_heat, output ready);
endinterface

// ===== sv/att_rsp_if.sv =====
`timescale 1ns / 1ps
// att_rsp_if: result item channel, valid/ready handshake with payload
// no dependencies

interface att_rsp_if;
   logic       valid;
   logic       ready;
   logic       foot_light_on;
   logic       red_light_on;
   logic       locked;
   logic       up_active;
   logic       down_active;
   logic       motor_off_pulse;
   logic       tx_valid;
   logic [7:0] tx_code;

   modport source (output valid, foot_light_on, red_light_on, locked, up_active,
                   down_active, motor_off_pulse, tx_valid, tx_code, input ready);
   modport sink (input valid, foot_light_on, red_light_on, locked, up_active,
                 down_active, motor_off_pulse, tx_valid, tx_code, output ready);
endinterface

// ===== sv/att_csr.sv =====
`timescale 1ns / 1ps
// att_csr: configuration registers of the tick timer set
// depends on att_pkg

module att_csr
   import att_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output att_cfg_type           cfg
);

   att_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MASS_TIMEOUT:      cfg_in.mass_timeout = csr_wdata;
            REG_HEAT_TIMEOUT:      cfg_in.heat_timeout = csr_wdata;
            REG_MOTOR_PHASE_LIMIT: cfg_in.motor_phase_limit = csr_wdata;
            REG_LOCK_HOLD_LIMIT:   cfg_in.lock_hold_limit = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mass_timeout <= MASS_TIMEOUT_RST;
         cfg_ff.heat_timeout <= HEAT_TIMEOUT_RST;
         cfg_ff.motor_phase_limit <= MOTOR_PHASE_LIMIT_RST;
         cfg_ff.lock_hold_limit <= LOCK_HOLD_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/att_tick.sv =====
`timescale 1ns / 1ps
// att_tick: timer state and the per-tick update, one item per enabled cycle
// depends on att_pkg

module att_tick
   import att_pkg::*;
#(
   parameter int PWM_TOP = PWM_TOP_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  att_cfg_type cfg,
   input  att_req_type req,
   output att_rsp_type rsp
);

   localparam int PHASE_W = $clog2(PWM_TOP + 1);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               lock_ff, lock_in;
   logic [15:0]        hold_ff, hold_in;
   logic               red_ff, red_in;
   logic               up_ff, up_in;
   logic               down_ff, down_in;
   logic [15:0]        up_cnt_ff, up_cnt_in;
   logic [15:0]        down_cnt_ff, down_cnt_in;
   logic               mass_arm_ff, mass_arm_in;
   logic [15:0]        mass_cnt_ff, mass_cnt_in;
   logic               heat_arm_ff, heat_arm_in;
   logic [15:0]        heat_cnt_ff, heat_cnt_in;

   logic        up_set, down_mid, up_mid, pulse, tx;
   logic [15:0] up_inc, down_inc;
   logic [7:0]  code;

   always_comb begin
      // pwm phase
      if (phase_ff == PHASE_W'(PWM_TOP)) begin
         phase_in = '0;
      end else begin
         phase_in = phase_ff + PHASE_W'(1);
      end

      // key lock
      lock_in = lock_ff;
      hold_in = hold_ff;
      red_in = red_ff;
      if (req.lock_key_seen) begin
         if (hold_ff < cfg.lock_hold_limit) begin
            hold_in = hold_ff + 16'd1;
         end else begin
            hold_in = '0;
            red_in = lock_ff;
            lock_in = !lock_ff;
         end
      end

      // motor phases
      pulse = 1'b0;
      up_set = up_ff | req.set_up;
      up_mid = up_set;
      down_mid = down_ff | req.set_down;
      up_inc = up_cnt_ff + 16'd1;
      down_inc = down_cnt_ff + 16'd1;
      up_cnt_in = up_cnt_ff;
      down_cnt_in = down_cnt_ff;
      if (up_set) begin
         up_cnt_in = up_inc;
         if (up_inc > cfg.motor_phase_limit) begin
            up_cnt_in = '0;
            up_mid = 1'b0;
            down_mid = 1'b1;
            pulse = 1'b1;
         end
      end
      up_in = up_mid;
      down_in = down_mid;
      if (down_mid) begin
         down_cnt_in = down_inc;
         if (down_inc > cfg.motor_phase_limit) begin
            down_cnt_in = '0;
            up_in = 1'b1;
            down_in = 1'b0;
            pulse = 1'b1;
         end
      end

      // auto-close timers, heat wins
      tx = 1'b0;
      code = CODE_NONE;
      mass_arm_in = mass_arm_ff | req.arm_mass;
      mass_cnt_in = mass_cnt_ff;
      if (mass_arm_in) begin
         mass_cnt_in = mass_cnt_ff + 16'd1;
         if (mass_cnt_ff > cfg.mass_timeout) begin
            mass_cnt_in = '0;
            mass_arm_in = 1'b0;
            tx = 1'b1;
            code = CODE_MASS_OFF;
         end
      end
      heat_arm_in = heat_arm_ff | req.arm_heat;
      heat_cnt_in = heat_cnt_ff;
      if (heat_arm_in) begin
         heat_cnt_in = heat_cnt_ff + 16'd1;
         if (heat_cnt_ff > cfg.heat_timeout) begin
            heat_cnt_in = '0;
            heat_arm_in = 1'b0;
            red_in = 1'b0;
            tx = 1'b1;
            code = CODE_HEAT_OFF;
         end
      end
   end

   always_comb begin
      rsp.foot_light_on = {{(8 - PHASE_W){1'b0}}, phase_in} < req.light_level;
      rsp.red_light_on = red_in;
      rsp.locked = lock_in;
      rsp.up_active = up_in;
      rsp.down_active = down_in;
      rsp.motor_off_pulse = pulse;
      rsp.tx_valid = tx;
      rsp.tx_code = code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         lock_ff <= 1'b1;
         hold_ff <= '0;
         red_ff <= 1'b0;
         up_ff <= 1'b0;
         down_ff <= 1'b0;
         up_cnt_ff <= '0;
         down_cnt_ff <= '0;
         mass_arm_ff <= 1'b0;
         mass_cnt_ff <= '0;
         heat_arm_ff <= 1'b0;
         heat_cnt_ff <= '0;
      end else if (enable) begin
         phase_ff <= phase_in;
         lock_ff <= lock_in;
         hold_ff <= hold_in;
         red_ff <= red_in;
         up_ff <= up_in;
         down_ff <= down_in;
         up_cnt_ff <= up_cnt_in;
         down_cnt_ff <= down_cnt_in;
         mass_arm_ff <= mass_arm_in;
         mass_cnt_ff <= mass_cnt_in;
         heat_arm_ff <= heat_arm_in;
         heat_cnt_ff <= heat_cnt_in;
      end
   end

endmodule

// ===== sv/appliance_tick_timer_set_top.sv =====
`timescale 1ns / 1ps
// appliance_tick_timer_set_top: item input register, tick update, result register
// depends on att_pkg, att_req_if, att_rsp_if, att_csr, att_tick

// Each accepted req item is one timer tick and yields exactly one rsp item. The
// block takes one item per clock cycle while rsp takes its items: an item is held
// in the input register, the tick update runs as one short pass of 16-bit counter
// adds and compares, and the result lands in the output register, which drives rsp
// valid. Back pressure on rsp stalls the input register only when both registers
// are full. Configuration writes through csr_ are taken at any time but should be
// made only while no item is in flight.

module appliance_tick_timer_set_top
   import att_pkg::*;
#(
   parameter int PWM_TOP = PWM_TOP_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   att_req_if.sink               req_if,
   att_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   att_cfg_type cfg;
   att_req_type in_data_ff, in_data_in;
   att_rsp_type out_data_ff, step_rsp;
   logic        in_valid_ff, in_valid_in;
   logic        out_valid_ff, out_valid_in;
   logic        advance, req_take;

   att_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   att_tick #(
      .PWM_TOP (PWM_TOP)
   ) u_tick (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .cfg    (cfg),
      .req    (in_data_ff),
      .rsp    (step_rsp)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take = req_if.valid && req_if.ready;

   always_comb begin
      in_data_in.light_level = req_if.light_level;
      in_data_in.lock_key_seen = req_if.lock_key_seen;
      in_data_in.set_up = req_if.set_up;
      in_data_in.set_down = req_if.set_down;
      in_data_in.arm_mass = req_if.arm_mass;
      in_data_in.arm_heat = req_if.arm_heat;
      in_valid_in = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= in_data_in;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.foot_light_on = out_data_ff.foot_light_on;
   assign rsp_if.red_light_on = out_data_ff.red_light_on;
   assign rsp_if.locked = out_data_ff.locked;
   assign rsp_if.up_active = out_data_ff.up_active;
   assign rsp_if.down_active = out_data_ff.down_active;
   assign rsp_if.motor_off_pulse = out_data_ff.motor_off_pulse;
   assign rsp_if.tx_valid = out_data_ff.tx_valid;
   assign rsp_if.tx_code = out_data_ff.tx_code;

   // a swap leaves exactly one motor phase active
   a_pulse_one_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.motor_off_pulse) |-> (rsp_if.up_active != rsp_if.down_active))
      else $error("motor swap left both or neither phase active");

   // close code matches tx valid
   a_tx_code: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.tx_valid ?
         (rsp_if.tx_code == CODE_MASS_OFF || rsp_if.tx_code == CODE_HEAT_OFF) :
         (rsp_if.tx_code == CODE_NONE)))
      else $error("tx code inconsistent with tx valid");

   // an item is never taken over one that is still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_take && in_valid_ff && !advance))
      else $error("input register overrun");

   // a stalled result is not dropped
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_if.ready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("result register changed while stalled");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for appliance_tick_timer_set_top, one tick per req item
// depends on att_pkg, att_req_if, att_rsp_if and the block's rtl

module testbench;
   import att_pkg::*;

   localparam int PWM_TOP = PWM_TOP_DEF;
   localparam int REG_COUNT = 4;
   localparam int LATENCY = 2;
   localparam int STALL_LIMIT = 1000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   att_req_if req_if();
   att_rsp_if rsp_if();

   appliance_tick_timer_set_top #(.PWM_TOP(PWM_TOP)) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predicted block state
   att_cfg_type cfg_shadow = '{MASS_TIMEOUT_RST, HEAT_TIMEOUT_RST,
                               MOTOR_PHASE_LIMIT_RST, LOCK_HOLD_LIMIT_RST};
   logic [6:0]  pwm_phase = '0;
   logic        lock_flag = 1'b1;
   logic [15:0] lock_count = '0;
   logic        red_light = 1'b0;
   logic        up_flag = 1'b0;
   logic        down_phase = 1'b0;
   logic [15:0] up_count = '0;
   logic [15:0] down_count = '0;
   logic        mass_armed = 1'b0;
   logic [15:0] mass_count = '0;
   logic        heat_armed = 1'b0;
   logic [15:0] heat_count = '0;

   att_rsp_type status_queue[$];
   int mismatches = 0;
   bit idle_on = 1'b1;
   int hold_request = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic att_rsp_type predict_tick(input att_req_type t);
      att_rsp_type res;
      logic [7:0]  next_phase;
      logic [15:0] prev;
      res = '0;
      res.tx_code = CODE_NONE;
      if (t.set_up) up_flag = 1'b1;
      if (t.set_down) down_phase = 1'b1;
      if (t.arm_mass) mass_armed = 1'b1;
      if (t.arm_heat) heat_armed = 1'b1;

      next_phase = {1'b0, pwm_phase} + 8'd1;
      if (next_phase > PWM_TOP) next_phase = '0;
      pwm_phase = next_phase[6:0];

      if (t.lock_key_seen) begin
         if (lock_count < cfg_shadow.lock_hold_limit) begin
            lock_count = lock_count + 16'd1;
         end else begin
            lock_count = '0;
            red_light = lock_flag;
            lock_flag = ~lock_flag;
         end
      end

      if (up_flag) begin
         up_count = up_count + 16'd1;
         if (up_count > cfg_shadow.motor_phase_limit) begin
            up_count = '0;
            up_flag = 1'b0;
            down_phase = 1'b1;
            res.motor_off_pulse = 1'b1;
         end
      end
      if (down_phase) begin
         down_count = down_count + 16'd1;
         if (down_count > cfg_shadow.motor_phase_limit) begin
            down_count = '0;
            up_flag = 1'b1;
            down_phase = 1'b0;
            res.motor_off_pulse = 1'b1;
         end
      end

      // compare uses the count before it steps
      if (mass_armed) begin
         prev = mass_count;
         mass_count = mass_count + 16'd1;
         if (prev > cfg_shadow.mass_timeout) begin
            mass_count = '0;
            mass_armed = 1'b0;
            res.tx_valid = 1'b1;
            res.tx_code = CODE_MASS_OFF;
         end
      end
      if (heat_armed) begin
         prev = heat_count;
         heat_count = heat_count + 16'd1;
         if (prev > cfg_shadow.heat_timeout) begin
            heat_count = '0;
            heat_armed = 1'b0;
            red_light = 1'b0;
            res.tx_valid = 1'b1;
            res.tx_code = CODE_HEAT_OFF;
         end
      end

      res.foot_light_on = ({1'b0, pwm_phase} < t.light_level);
      res.red_light_on = red_light;
      res.locked = lock_flag;
      res.up_active = up_flag;
      res.down_active = down_phase;
      return res;
   endfunction

   function automatic att_req_type mk_tick(input logic [7:0] level, input logic key,
                                           input logic up, input logic down,
                                           input logic mass, input logic heat);
      att_req_type t;
      t.light_level = level;
      t.lock_key_seen = key;
      t.set_up = up;
      t.set_down = down;
      t.arm_mass = mass;
      t.arm_heat = heat;
      return t;
   endfunction

   function automatic att_req_type random_tick(input int key_pct, input int arm_pct,
                                               input int set_pct);
      return mk_tick(8'($urandom_range(0, 255)),
                     $urandom_range(0, 99) < key_pct,
                     $urandom_range(0, 99) < set_pct,
                     $urandom_range(0, 99) < set_pct,
                     $urandom_range(0, 99) < arm_pct,
                     $urandom_range(0, 99) < arm_pct);
   endfunction

   function automatic att_cfg_type random_config(input int max_timeout, input int max_limit);
      att_cfg_type c;
      c.mass_timeout = 16'($urandom_range(0, max_timeout));
      c.heat_timeout = 16'($urandom_range(0, max_timeout));
      c.motor_phase_limit = 16'($urandom_range(1, max_limit));
      c.lock_hold_limit = 16'($urandom_range(1, max_limit));
      return c;
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_MASS_TIMEOUT: cfg_shadow.mass_timeout = val;
         REG_HEAT_TIMEOUT: cfg_shadow.heat_timeout = val;
         REG_MOTOR_PHASE_LIMIT: cfg_shadow.motor_phase_limit = val;
         REG_LOCK_HOLD_LIMIT: cfg_shadow.lock_hold_limit = val;
         default: ;
      endcase
   endtask

   // every register, then one write to an unused index that must be ignored
   task automatic apply_config(input att_cfg_type c);
      csr_put(REG_MASS_TIMEOUT, c.mass_timeout);
      csr_put(REG_HEAT_TIMEOUT, c.heat_timeout);
      csr_put(REG_MOTOR_PHASE_LIMIT, c.motor_phase_limit);
      csr_put(REG_LOCK_HOLD_LIMIT, c.lock_hold_limit);
      csr_put(CSR_IDX_W'($urandom_range(REG_COUNT, 2 ** CSR_IDX_W - 1)),
              16'($urandom_range(0, 65535)));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_tick(input att_req_type t);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.light_level <= t.light_level;
      req_if.lock_key_seen <= t.lock_key_seen;
      req_if.set_up <= t.set_up;
      req_if.set_down <= t.set_down;
      req_if.arm_mass <= t.arm_mass;
      req_if.arm_heat <= t.arm_heat;
      do @(posedge clock); while (!req_if.ready);
      status_queue.push_back(predict_tick(t));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (status_queue.size() != 0);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic test_defaults_after_reset();
      send_tick(mk_tick(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      send_tick(mk_tick(8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'h7f, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_tick(mk_tick(8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'd101, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      wait_idle();
   endtask

   // zero timeouts and unit limits: collisions, fast toggles and swaps
   task automatic test_limit_corners();
      apply_config('{16'd0, 16'd0, 16'd1, 16'd1});
      send_tick(mk_tick(8'd50, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      send_tick(mk_tick(8'd50, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      send_tick(mk_tick(8'd50, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'd50, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
      send_tick(mk_tick(8'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'd200, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
      send_tick(mk_tick(8'd200, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_tick(mk_tick(8'd200, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_tick(mk_tick(8'd200, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      wait_idle();
   endtask

   task automatic test_random_ticks(input att_cfg_type c, input int count, input int key_pct,
                                    input int arm_pct, input int set_pct);
      apply_config(c);
      repeat (count) send_tick(random_tick(key_pct, arm_pct, set_pct));
      wait_idle();
   endtask

   // rsp side holds off long enough for the block to fill and stall req
   task automatic test_output_stall();
      apply_config(random_config(30, 10));
      hold_request = 48;
      repeat (60) send_tick(random_tick(70, 10, 10));
      wait_idle();
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.light_level <= '0;
      req_if.lock_key_seen <= 1'b0;
      req_if.set_up <= 1'b0;
      req_if.set_down <= 1'b0;
      req_if.arm_mass <= 1'b0;
      req_if.arm_heat <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults_after_reset();
      test_limit_corners();
      test_random_ticks(random_config(30, 15), 400, 70, 10, 8);
      test_random_ticks('{16'd0, 16'd0, 16'd1, 16'd1}, 200, 60, 30, 20);
      test_random_ticks('{16'hffff, 16'hffff, 16'hffff, 16'hffff}, 150, 80, 20, 20);
      test_random_ticks('{MASS_TIMEOUT_RST, HEAT_TIMEOUT_RST, MOTOR_PHASE_LIMIT_RST,
                          LOCK_HOLD_LIMIT_RST}, 150, 50, 5, 5);
      test_output_stall();
      repeat (4) test_random_ticks(random_config(60, 40), 150, 70, 8, 6);
      idle_on = 1'b0;
      test_random_ticks(random_config(20, 10), 200, 70, 10, 8);

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_request > 0) begin
            stall_left = hold_request - 1;
            hold_request = 0;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      att_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (status_queue.size() == 0) begin
            $error("rsp item with no tick outstanding");
            mismatches++;
         end else begin
            want = status_queue.pop_front();
            compare_field("foot_light_on", 8'(want.foot_light_on),
                          8'(rsp_if.foot_light_on));
            compare_field("red_light_on", 8'(want.red_light_on),
                          8'(rsp_if.red_light_on));
            compare_field("locked", 8'(want.locked), 8'(rsp_if.locked));
            compare_field("up_active", 8'(want.up_active), 8'(rsp_if.up_active));
            compare_field("down_active", 8'(want.down_active),
                          8'(rsp_if.down_active));
            compare_field("motor_off_pulse", 8'(want.motor_off_pulse),
                          8'(rsp_if.motor_off_pulse));
            compare_field("tx_valid", 8'(want.tx_valid), 8'(rsp_if.tx_valid));
            compare_field("tx_code", want.tx_code, rsp_if.tx_code);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
sv/att_pkg.sv
sv/att_req_if.sv
sv/att_rsp_if.sv
sv/att_csr.sv
sv/att_tick.sv
sv/appliance_tick_timer_set_top.sv
sim/testbench.sv
